// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks with active-low reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- rtl/mcd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types, code-set tables and constants for the codeword decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcd_pkg;

  localparam int CW_W        = 6;
  localparam int VALUE_W     = 20;
  localparam int GVAL_W      = 30;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int SET_W       = 3;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_DIGIT  = 2'd1,
    KIND_ECI    = 2'd2,
    KIND_APPEND = 2'd3
  } kind_t;

  // KIND_DIGIT in a command carries a whole numeric group
  typedef struct packed {
    kind_t              kind;
    logic [GVAL_W-1:0]  value;
    logic [IDX_W-1:0]   app_idx;
    logic [CNT_W-1:0]   app_cnt;
  } cmd_t;

  typedef logic [8:0] sym_t;

  localparam sym_t SYM_SH0 = 9'h100;
  localparam sym_t SYM_SH1 = 9'h101;
  localparam sym_t SYM_SH2 = 9'h102;
  localparam sym_t SYM_SH3 = 9'h103;
  localparam sym_t SYM_SH4 = 9'h104;
  localparam sym_t SYM_TWO = 9'h105;
  localparam sym_t SYM_THR = 9'h106;
  localparam sym_t SYM_LA  = 9'h107;
  localparam sym_t SYM_LB  = 9'h108;
  localparam sym_t SYM_LK  = 9'h109;
  localparam sym_t SYM_EC  = 9'h10A;
  localparam sym_t SYM_NU  = 9'h10B;
  localparam sym_t SYM_PD  = 9'h10C;

  localparam sym_t CS_A [64] = '{
    9'h00D, 9'h041, 9'h042, 9'h043, 9'h044, 9'h045, 9'h046, 9'h047,
    9'h048, 9'h049, 9'h04A, 9'h04B, 9'h04C, 9'h04D, 9'h04E, 9'h04F,
    9'h050, 9'h051, 9'h052, 9'h053, 9'h054, 9'h055, 9'h056, 9'h057,
    9'h058, 9'h059, 9'h05A, SYM_EC, 9'h01C, 9'h01D, 9'h01E, SYM_NU,
    9'h020, SYM_PD, 9'h022, 9'h023, 9'h024, 9'h025, 9'h026, 9'h027,
    9'h028, 9'h029, 9'h02A, 9'h02B, 9'h02C, 9'h02D, 9'h02E, 9'h02F,
    9'h030, 9'h031, 9'h032, 9'h033, 9'h034, 9'h035, 9'h036, 9'h037,
    9'h038, 9'h039, 9'h03A, SYM_SH1, SYM_SH2, SYM_SH3, SYM_SH4, SYM_LB
  };

  localparam sym_t CS_B [64] = '{
    9'h060, 9'h061, 9'h062, 9'h063, 9'h064, 9'h065, 9'h066, 9'h067,
    9'h068, 9'h069, 9'h06A, 9'h06B, 9'h06C, 9'h06D, 9'h06E, 9'h06F,
    9'h070, 9'h071, 9'h072, 9'h073, 9'h074, 9'h075, 9'h076, 9'h077,
    9'h078, 9'h079, 9'h07A, SYM_EC, 9'h01C, 9'h01D, 9'h01E, SYM_NU,
    9'h07B, SYM_PD, 9'h07D, 9'h07E, 9'h07F, 9'h03B, 9'h03C, 9'h03D,
    9'h03E, 9'h03F, 9'h05B, 9'h05C, 9'h05D, 9'h05E, 9'h05F, 9'h020,
    9'h02C, 9'h02E, 9'h02F, 9'h03A, 9'h040, 9'h021, 9'h07C, SYM_PD,
    SYM_TWO, SYM_THR, SYM_PD, SYM_SH0, SYM_SH2, SYM_SH3, SYM_SH4, SYM_LA
  };

  localparam sym_t CS_C [64] = '{
    9'h0C0, 9'h0C1, 9'h0C2, 9'h0C3, 9'h0C4, 9'h0C5, 9'h0C6, 9'h0C7,
    9'h0C8, 9'h0C9, 9'h0CA, 9'h0CB, 9'h0CC, 9'h0CD, 9'h0CE, 9'h0CF,
    9'h0D0, 9'h0D1, 9'h0D2, 9'h0D3, 9'h0D4, 9'h0D5, 9'h0D6, 9'h0D7,
    9'h0D8, 9'h0D9, 9'h0DA, SYM_EC, 9'h01C, 9'h01D, 9'h01E, SYM_NU,
    9'h0DB, 9'h0DC, 9'h0DD, 9'h0DE, 9'h0DF, 9'h0AA, 9'h0AC, 9'h0B1,
    9'h0B2, 9'h0B3, 9'h0B5, 9'h0B9, 9'h0BA, 9'h0BC, 9'h0BD, 9'h0BE,
    9'h080, 9'h081, 9'h082, 9'h083, 9'h084, 9'h085, 9'h086, 9'h087,
    9'h088, 9'h089, SYM_LA, 9'h020, SYM_LK, SYM_SH3, SYM_SH4, SYM_LB
  };

  localparam sym_t CS_D [64] = '{
    9'h0E0, 9'h0E1, 9'h0E2, 9'h0E3, 9'h0E4, 9'h0E5, 9'h0E6, 9'h0E7,
    9'h0E8, 9'h0E9, 9'h0EA, 9'h0EB, 9'h0EC, 9'h0ED, 9'h0EE, 9'h0EF,
    9'h0F0, 9'h0F1, 9'h0F2, 9'h0F3, 9'h0F4, 9'h0F5, 9'h0F6, 9'h0F7,
    9'h0F8, 9'h0F9, 9'h0FA, SYM_EC, 9'h01C, 9'h01D, 9'h01E, SYM_NU,
    9'h0FB, 9'h0FC, 9'h0FD, 9'h0FE, 9'h0FF, 9'h0A1, 9'h0A8, 9'h0AB,
    9'h0AF, 9'h0B0, 9'h0B4, 9'h0B7, 9'h0B8, 9'h0BB, 9'h0BF, 9'h08A,
    9'h08B, 9'h08C, 9'h08D, 9'h08E, 9'h08F, 9'h090, 9'h091, 9'h092,
    9'h093, 9'h094, SYM_LA, 9'h020, SYM_SH2, SYM_LK, SYM_SH4, SYM_LB
  };

  localparam sym_t CS_E [64] = '{
    9'h000, 9'h001, 9'h002, 9'h003, 9'h004, 9'h005, 9'h006, 9'h007,
    9'h008, 9'h009, 9'h00A, 9'h00B, 9'h00C, 9'h00D, 9'h00E, 9'h00F,
    9'h010, 9'h011, 9'h012, 9'h013, 9'h014, 9'h015, 9'h016, 9'h017,
    9'h018, 9'h019, 9'h01A, SYM_EC, SYM_PD, SYM_PD, 9'h01B, SYM_NU,
    9'h01C, 9'h01D, 9'h01E, 9'h01F, 9'h09F, 9'h0A0, 9'h0A2, 9'h0A3,
    9'h0A4, 9'h0A5, 9'h0A6, 9'h0A7, 9'h0A9, 9'h0AD, 9'h0AE, 9'h0B6,
    9'h095, 9'h096, 9'h097, 9'h098, 9'h099, 9'h09A, 9'h09B, 9'h09C,
    9'h09D, 9'h09E, SYM_LA, 9'h020, SYM_SH2, SYM_SH3, SYM_LK, SYM_LB
  };

  function automatic sym_t sym_lookup(input logic [SET_W-1:0] set_sel,
                                      input logic [CW_W-1:0] cw);
    sym_t s;
    case (set_sel)
      3'd1:    s = CS_B[cw];
      3'd2:    s = CS_C[cw];
      3'd3:    s = CS_D[cw];
      3'd4:    s = CS_E[cw];
      default: s = CS_A[cw];
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/mcd_queue.sv -----
// ----------------------------------------------------------------------------
// mcd_queue
// Small command FIFO between the classifier and the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcd_queue #(
  parameter int DEPTH = mcd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mcd_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output mcd_pkg::cmd_t pop_data
);
  import mcd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  cmd_t               mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W_Q'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_NEVER(a_push_full, clk, rst_n, push && full)
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !pop_valid)
  `ASSERT_CLK(a_ptr_match, clk, rst_n, (count_r == '0 || full) |-> (wr_ptr_r == rd_ptr_r))

endmodule

// ----- rtl/mcd_front.sv -----
// ----------------------------------------------------------------------------
// mcd_front
// Codeword classifier: tracks code set, shifts and open groups, and turns
// each beat into at most one command for the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcd_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [mcd_pkg::CW_W-1:0] in_codeword,
  input  logic                     in_first_of_message,
  input  logic                     in_last_of_message,
  input  logic                     q_full,
  output logic                     q_push,
  output mcd_pkg::cmd_t            q_data
);
  import mcd_pkg::*;

  typedef enum logic [1:0] {GK_NONE, GK_NUM, GK_ECI, GK_SA} grp_t;

  localparam logic [2:0] SHIFT_NONE = 3'd7;
  localparam logic [2:0] NUM_LEN    = 3'd5;

  logic [SET_W-1:0]  cur_set_r, cur_set_nxt;
  logic [SET_W-1:0]  saved_set_r, saved_set_nxt;
  logic [2:0]        shift_r, shift_nxt;
  grp_t              grp_r, grp_nxt;
  logic [2:0]        grem_r, grem_nxt;
  logic [GVAL_W-1:0] gval_r, gval_nxt;

  logic              accept;
  logic              cmd_vld;
  cmd_t              cmd;
  sym_t              sym;
  logic [IDX_W-1:0]  sa_idx;
  logic [CNT_W-1:0]  sa_cnt;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && cmd_vld;
  assign q_data   = cmd;

  assign sa_idx = in_codeword[5:3];

  always_comb begin
    cur_set_nxt   = cur_set_r;
    saved_set_nxt = saved_set_r;
    shift_nxt     = shift_r;
    grp_nxt       = grp_r;
    grem_nxt      = grem_r;
    gval_nxt      = gval_r;
    cmd_vld       = 1'b0;
    cmd           = '0;
    sym           = '0;
    sa_cnt        = {1'b0, in_codeword[2:0]} + 4'd1;

    if (in_first_of_message) begin
      cur_set_nxt   = '0;
      saved_set_nxt = '0;
      shift_nxt     = SHIFT_NONE;
      grp_nxt       = GK_NONE;
      grem_nxt      = '0;
      gval_nxt      = '0;
    end

    unique case (grp_nxt)
      GK_NUM: begin
        gval_nxt = {gval_nxt[GVAL_W-CW_W-1:0], in_codeword};
        if (grem_nxt != '0) begin
          grem_nxt = grem_nxt - 3'd1;
        end
        if (grem_nxt == '0) begin
          grp_nxt   = GK_NONE;
          cmd_vld   = 1'b1;
          cmd.kind  = KIND_DIGIT;
          cmd.value = gval_nxt;
        end
      end
      GK_ECI: begin
        if (grem_nxt == '0) begin
          if (!in_codeword[5]) begin
            grp_nxt   = GK_NONE;
            cmd_vld   = 1'b1;
            cmd.kind  = KIND_ECI;
            cmd.value = GVAL_W'(in_codeword);
          end else if (!in_codeword[4]) begin
            gval_nxt = GVAL_W'(in_codeword[3:0]);
            grem_nxt = 3'd1;
          end else if (!in_codeword[3]) begin
            gval_nxt = GVAL_W'(in_codeword[2:0]);
            grem_nxt = 3'd2;
          end else begin
            gval_nxt = GVAL_W'(in_codeword[1:0]);
            grem_nxt = 3'd3;
          end
        end else begin
          gval_nxt = GVAL_W'({gval_nxt[VALUE_W-CW_W-1:0], in_codeword});
          grem_nxt = grem_nxt - 3'd1;
          if (grem_nxt == '0) begin
            grp_nxt   = GK_NONE;
            cmd_vld   = 1'b1;
            cmd.kind  = KIND_ECI;
            cmd.value = gval_nxt;
          end
        end
      end
      GK_SA: begin
        if (sa_cnt == 4'd1 || sa_cnt <= {1'b0, sa_idx}) begin
          sa_cnt = '0;
        end
        grp_nxt     = GK_NONE;
        grem_nxt    = '0;
        cmd_vld     = 1'b1;
        cmd.kind    = KIND_APPEND;
        cmd.app_idx = sa_idx;
        cmd.app_cnt = sa_cnt;
      end
      default: begin
        sym = sym_lookup(cur_set_nxt, in_codeword);
        unique case (sym) inside
          SYM_LA: begin
            cur_set_nxt = 3'd0;
            shift_nxt   = SHIFT_NONE;
          end
          SYM_LB: begin
            cur_set_nxt = 3'd1;
            shift_nxt   = SHIFT_NONE;
          end
          SYM_SH0, SYM_SH1, SYM_SH2, SYM_SH3, SYM_SH4: begin
            saved_set_nxt = cur_set_nxt;
            cur_set_nxt   = sym[SET_W-1:0];
            shift_nxt     = 3'd1;
          end
          SYM_TWO: begin
            saved_set_nxt = cur_set_nxt;
            cur_set_nxt   = 3'd0;
            shift_nxt     = 3'd2;
          end
          SYM_THR: begin
            saved_set_nxt = cur_set_nxt;
            cur_set_nxt   = 3'd0;
            shift_nxt     = 3'd3;
          end
          SYM_LK: begin
            shift_nxt = SHIFT_NONE;
          end
          SYM_NU: begin
            grp_nxt  = GK_NUM;
            grem_nxt = NUM_LEN;
            gval_nxt = '0;
          end
          SYM_EC: begin
            grp_nxt  = GK_ECI;
            grem_nxt = '0;
            gval_nxt = '0;
          end
          SYM_PD: begin
            if (in_first_of_message) begin
              grp_nxt  = GK_SA;
              grem_nxt = 3'd1;
            end
            shift_nxt = SHIFT_NONE;
          end
          default: begin
            cmd_vld   = 1'b1;
            cmd.kind  = KIND_TEXT;
            cmd.value = GVAL_W'(sym[7:0]);
          end
        endcase
        // shift countdown; saved set returns on expiry
        if (shift_nxt != SHIFT_NONE) begin
          if (shift_nxt == 3'd0) begin
            cur_set_nxt = saved_set_nxt;
            shift_nxt   = SHIFT_NONE;
          end else begin
            shift_nxt = shift_nxt - 3'd1;
          end
        end
      end
    endcase

    if (in_last_of_message) begin
      cur_set_nxt   = '0;
      saved_set_nxt = '0;
      shift_nxt     = SHIFT_NONE;
      grp_nxt       = GK_NONE;
      grem_nxt      = '0;
      gval_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_set_r   <= '0;
      saved_set_r <= '0;
      shift_r     <= SHIFT_NONE;
      grp_r       <= GK_NONE;
      grem_r      <= '0;
      gval_r      <= '0;
    end else if (accept) begin
      cur_set_r   <= cur_set_nxt;
      saved_set_r <= saved_set_nxt;
      shift_r     <= shift_nxt;
      grp_r       <= grp_nxt;
      grem_r      <= grem_nxt;
      gval_r      <= gval_nxt;
    end
  end

  `ASSERT_NEVER(a_num_rem, clk, rst_n, (grp_r == GK_NUM) && (grem_r == '0 || grem_r > NUM_LEN))
  `ASSERT_NEVER(a_eci_rem, clk, rst_n, (grp_r == GK_ECI) && (grem_r > 3'd3))
  `ASSERT_NEVER(a_set_rng, clk, rst_n, (cur_set_r > 3'd4) || (saved_set_r > 3'd4))
  `ASSERT_NEVER(a_shift_rng, clk, rst_n, (shift_r == 3'd4) || (shift_r == 3'd5) || (shift_r == 3'd6))

endmodule

// ----- rtl/mcd_back.sv -----
// ----------------------------------------------------------------------------
// mcd_back
// Result emitter: single results go straight to the output register;
// numeric groups are converted to BCD, then sent one digit per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mcd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  mcd_pkg::cmd_t               q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [mcd_pkg::VALUE_W-1:0] out_value,
  output logic [mcd_pkg::IDX_W-1:0]   out_append_index,
  output logic [mcd_pkg::CNT_W-1:0]   out_append_count,
  output logic                        out_last_of_run
);
  import mcd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  localparam int DIGITS     = 10;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int STEP_BITS  = 3;
  localparam int CONV_STEPS = GVAL_W / STEP_BITS;
  localparam logic [3:0] STEP_LAST  = 4'(CONV_STEPS - 1);
  localparam logic [3:0] ASCII_ZERO = 4'h3;

  state_t            state_r;
  logic [GVAL_W-1:0] bin_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [BCD_W-1:0]  bcd_step;
  logic [3:0]        step_r;
  logic [3:0]        dig_r;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [VALUE_W-1:0] out_value_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [CNT_W-1:0]  out_cnt_r;
  logic              out_last_r;
  logic              out_free;
  logic              out_load;

  // shift-add-3 over STEP_BITS input bits
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd_in,
                                               input logic [STEP_BITS-1:0] bits);
    logic [BCD_W-1:0] b;
    b = bcd_in;
    for (int k = STEP_BITS - 1; k >= 0; k--) begin
      for (int d = 0; d < DIGITS; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[BCD_W-2:0], bits[k]};
    end
    return b;
  endfunction

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid && out_free;
  assign out_load = (q_pop && (q_data.kind != KIND_DIGIT)) ||
                    ((state_r == S_EMIT) && out_free);
  assign bcd_step = dabble(bcd_r, bin_r[GVAL_W-1 -: STEP_BITS]);

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_value        = out_value_r;
  assign out_append_index = out_idx_r;
  assign out_append_count = out_cnt_r;
  assign out_last_of_run  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            if (q_data.kind == KIND_DIGIT) begin
              bin_r   <= q_data.value;
              bcd_r   <= '0;
              step_r  <= '0;
              state_r <= S_CONV;
            end else begin
              out_kind_r  <= q_data.kind;
              out_value_r <= q_data.value[VALUE_W-1:0];
              out_idx_r   <= q_data.app_idx;
              out_cnt_r   <= q_data.app_cnt;
              out_last_r  <= 1'b1;
            end
          end
        end
        S_CONV: begin
          bin_r  <= bin_r << STEP_BITS;
          step_r <= step_r + 4'd1;
          if (step_r == STEP_LAST) begin
            state_r <= S_EMIT;
            // nine digits with leading zeros unless the value needs ten
            if (bcd_step[BCD_W-1 -: 4] == 4'd0) begin
              bcd_r <= {bcd_step[BCD_W-5:0], 4'd0};
              dig_r <= 4'(DIGITS - 2);
            end else begin
              bcd_r <= bcd_step;
              dig_r <= 4'(DIGITS - 1);
            end
          end else begin
            bcd_r <= bcd_step;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_kind_r  <= KIND_DIGIT;
            out_value_r <= VALUE_W'({ASCII_ZERO, bcd_r[BCD_W-1 -: 4]});
            out_idx_r   <= '0;
            out_cnt_r   <= '0;
            out_last_r  <= (dig_r == 4'd0);
            bcd_r       <= {bcd_r[BCD_W-5:0], 4'd0};
            dig_r       <= dig_r - 4'd1;
            if (dig_r == 4'd0) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_conv_done, clk, rst_n, (state_r == S_CONV && step_r == STEP_LAST) |=> (state_r == S_EMIT))
  `ASSERT_CLK(a_run_digits, clk, rst_n, (out_valid_r && !out_last_r) |-> (out_kind_r == KIND_DIGIT))
  `ASSERT_CLK(a_bcd_digit, clk, rst_n, (state_r == S_EMIT) |-> (bcd_r[BCD_W-1 -: 4] <= 4'd9))

endmodule

// ----- rtl/maxicode_codeword_text_decoder.sv -----
// ----------------------------------------------------------------------------
// maxicode_codeword_text_decoder
// MaxiCode message codeword to text/ECI/append result decoder.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one 6-bit codeword per beat with
//   message start and end flags. Result channel (out_valid/out_ready) gives
//   zero or more results per codeword; out_last_of_run marks the final one.
//   A classifier takes a codeword every cycle while the queue is not full and
//   queues at most one command per codeword; an emitter drains the queue into
//   a registered output. A text byte, ECI number or append result is queued,
//   then popped into the output register when the emitter is idle and the
//   output is free. A numeric group runs a binary-to-BCD conversion (3 bits
//   per cycle), then sends 9 or 10 digit results at one per cycle while the
//   output is taken. Throughput: one codeword per cycle for single-result
//   codewords while out_ready holds; the queue buffers commands behind a group.
//   in_ready drops only when the queue is full.
//   Reset (rst_n low, synchronous) restores set A, no shift, no open group,
//   and empties the queue and output register.
//   A stalled receiver holds the output beat; the queue then fills and
//   backpressure reaches the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maxicode_codeword_text_decoder #(
  parameter int QDEPTH = mcd_pkg::QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mcd_pkg::CW_W-1:0]    in_codeword,
  input  logic                        in_first_of_message,
  input  logic                        in_last_of_message,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_kind,
  output logic [mcd_pkg::VALUE_W-1:0] out_value,
  output logic [mcd_pkg::IDX_W-1:0]   out_append_index,
  output logic [mcd_pkg::CNT_W-1:0]   out_append_count,
  output logic                        out_last_of_run
);
  import mcd_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_wdata;
  logic q_pop;
  logic q_valid;
  cmd_t q_rdata;

  mcd_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_codeword         (in_codeword),
    .in_first_of_message (in_first_of_message),
    .in_last_of_message  (in_last_of_message),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_data              (q_wdata)
  );

  mcd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  mcd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_data           (q_rdata),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_value        (out_value),
    .out_append_index (out_append_index),
    .out_append_count (out_append_count),
    .out_last_of_run  (out_last_of_run)
  );

endmodule
